[rtl/core/huffman_code_builder_macros.svh]
// assertion helpers, clocked on clock and disabled in reset
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH

`define HCB_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define HCB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/hcb_pkg.sv]
package hcb_pkg;
   localparam int MAX_SYMBOLS = 64;
   localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
   localparam int MERGE_DEPTH = MAX_SYMBOLS - 1;
   localparam int FREQ_W      = 20;
   localparam int WEIGHT_W    = 26;
   localparam int CODE_W      = 63;
   localparam int LEN_W       = 6;
   localparam int IDX_W       = 6;
   localparam int NODE_W      = 7;
   localparam int CNT_W       = 7;

   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [NODE_W-1:0]   node_type;

   typedef struct packed {
      logic load;
      logic merge;
      logic root;
      logic single;
      logic tree_rd;
      logic wr_left;
      logic wr_right;
      logic emit_rd;
      logic emit_load;
      logic emit_next;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic len_gt1;
      logic no_merges;
      logic k_zero;
      logic emit_last;
   } sts_type;
endpackage

[rtl/core/hcb_ifs.sv]
interface hcb_req_if;
   logic                        valid;
   logic                        ready;
   logic [hcb_pkg::FREQ_W-1:0]  frequency;
   logic                        final_symbol;
   modport source (output valid, frequency, final_symbol, input ready);
   modport sink   (input valid, frequency, final_symbol, output ready);
endinterface

interface hcb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hcb_pkg::IDX_W-1:0]   symbol_index;
   logic [hcb_pkg::CODE_W-1:0]  code_value;
   logic [hcb_pkg::LEN_W-1:0]   code_length;
   logic                        overflow;
   logic                        last_code;
   modport source (output valid, symbol_index, code_value, code_length, overflow, last_code,
                   input ready);
   modport sink   (input valid, symbol_index, code_value, code_length, overflow, last_code,
                   output ready);
endinterface

[rtl/core/hcb_path.sv]
module hcb_path (
   input  logic                        clock,
   input  logic                        reset,
   input  hcb_pkg::cmd_type            cmd,
   output hcb_pkg::sts_type            sts,
   input  logic [hcb_pkg::FREQ_W-1:0]  frequency,
   output logic [hcb_pkg::IDX_W-1:0]   symbol_index,
   output logic [hcb_pkg::CODE_W-1:0]  code_value,
   output logic [hcb_pkg::LEN_W-1:0]   code_length,
   output logic                        overflow,
   output logic                        last_code
);
   import hcb_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in, len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] mrg_ff, mrg_in, k_ff, k_in, em_ff, em_in;
   weight_type       wt_ff [MAX_SYMBOLS];
   weight_type       wt_in [MAX_SYMBOLS];
   node_type         id_ff [MAX_SYMBOLS];
   node_type         id_in [MAX_SYMBOLS];

   node_type                  left_mem  [MERGE_DEPTH];
   node_type                  right_mem [MERGE_DEPTH];
   logic [CODE_W+LEN_W-1:0]   code_mem  [NODE_COUNT];

   node_type          lk_l_ff, lk_r_ff;
   logic [CODE_W-1:0] cb_ff;
   logic [LEN_W-1:0]  cl_ff;

   logic [IDX_W-1:0]  sym_ff;
   logic [CODE_W-1:0] code_ff;
   logic [LEN_W-1:0]  clen_ff;
   logic              oflag_ff, last_ff;

   weight_type             lw, mw;
   logic                   full, head_ins;
   logic [MAX_SYMBOLS-1:0] ge, ins, ins_prev, gt, gt_prev;
   node_type               new_node;

   logic                    we;
   node_type                wa, ra;
   logic [CODE_W+LEN_W-1:0] wd;

   assign lw       = WEIGHT_W'(frequency);
   assign mw       = wt_ff[0] + wt_ff[1];
   assign full     = (cnt_ff == CNT_W'(MAX_SYMBOLS));
   assign head_ins = (cnt_ff == '0) || (lw <= wt_ff[0]);
   assign new_node = NODE_W'(MAX_SYMBOLS) + NODE_W'(mrg_ff);
   assign ins_prev = {ins[MAX_SYMBOLS-2:0], 1'b0};
   assign gt_prev  = {gt[MAX_SYMBOLS-2:0], 1'b0};

   always_comb begin
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         ge[j] = (CNT_W'(j) >= cnt_ff) || (lw <= wt_ff[j]);
         gt[j] = (CNT_W'(j + 2) >= len_ff) ||
                 (wt_ff[(j + 2 < MAX_SYMBOLS) ? j + 2 : 0] > mw);
      end
      ins[0] = (cnt_ff == '0) || (lw < wt_ff[0]);
      for (int j = 1; j < MAX_SYMBOLS; j++) begin
         ins[j] = head_ins || ge[1] || ge[j];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      mrg_in = mrg_ff;
      k_in   = k_ff;
      em_in  = em_ff;
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         wt_in[j] = wt_ff[j];
         id_in[j] = id_ff[j];
      end
      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            len_in = len_ff + 1'b1;
            for (int j = 0; j < MAX_SYMBOLS; j++) begin
               if (ins[j] && !ins_prev[j]) begin
                  wt_in[j] = lw;
                  id_in[j] = NODE_W'(cnt_ff);
               end else if (ins[j]) begin
                  wt_in[j] = wt_ff[(j > 0) ? j - 1 : 0];
                  id_in[j] = id_ff[(j > 0) ? j - 1 : 0];
               end
            end
         end
      end
      if (cmd.merge) begin
         len_in = len_ff - 1'b1;
         mrg_in = mrg_ff + 1'b1;
         for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if (gt[j] && !gt_prev[j]) begin
               wt_in[j] = mw;
               id_in[j] = new_node;
            end else if (gt[j]) begin
               wt_in[j] = wt_ff[(j + 1 < MAX_SYMBOLS) ? j + 1 : 0];
               id_in[j] = id_ff[(j + 1 < MAX_SYMBOLS) ? j + 1 : 0];
            end else begin
               wt_in[j] = wt_ff[(j + 2 < MAX_SYMBOLS) ? j + 2 : 0];
               id_in[j] = id_ff[(j + 2 < MAX_SYMBOLS) ? j + 2 : 0];
            end
         end
      end
      if (cmd.root) begin
         k_in  = mrg_ff - 1'b1;
         em_in = '0;
      end
      if (cmd.single) begin
         em_in = '0;
      end
      if (cmd.wr_right) begin
         k_in = k_ff - 1'b1;
      end
      if (cmd.emit_next) begin
         em_in = em_ff + 1'b1;
      end
      if (cmd.clear) begin
         cnt_in = '0;
         len_in = '0;
         mrg_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_comb begin
      we = cmd.root || cmd.single || cmd.wr_left || cmd.wr_right;
      wa = new_node - 1'b1;
      wd = '0;
      if (cmd.single) begin
         wa = '0;
      end else if (cmd.wr_left) begin
         wa = lk_l_ff;
         wd = {cb_ff[CODE_W-2:0], 1'b0, cl_ff + 1'b1};
      end else if (cmd.wr_right) begin
         wa = lk_r_ff;
         wd = {cb_ff[CODE_W-2:0], 1'b1, cl_ff + 1'b1};
      end
      ra = cmd.tree_rd ? (NODE_W'(MAX_SYMBOLS) + NODE_W'(k_ff)) : NODE_W'(em_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         mrg_ff <= '0;
         k_ff   <= '0;
         em_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         mrg_ff <= mrg_in;
         k_ff   <= k_in;
         em_ff  <= em_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         wt_ff[j] <= wt_in[j];
         id_ff[j] <= id_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.merge) begin
         left_mem[mrg_ff]  <= id_ff[0];
         right_mem[mrg_ff] <= id_ff[1];
      end
      if (cmd.tree_rd) begin
         lk_l_ff <= left_mem[k_ff];
         lk_r_ff <= right_mem[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         code_mem[wa] <= wd;
      end
      if (cmd.tree_rd || cmd.emit_rd) begin
         {cb_ff, cl_ff} <= code_mem[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         sym_ff   <= em_ff;
         code_ff  <= cb_ff;
         clen_ff  <= cl_ff;
         oflag_ff <= ovf_ff;
         last_ff  <= sts.emit_last;
      end
   end

   assign sts.len_gt1   = (len_ff > CNT_W'(1));
   assign sts.no_merges = (mrg_ff == '0);
   assign sts.k_zero    = (k_ff == '0);
   assign sts.emit_last = ((CNT_W'(em_ff) + 1'b1) == cnt_ff);

   assign symbol_index = sym_ff;
   assign code_value   = code_ff;
   assign code_length  = clen_ff;
   assign overflow     = oflag_ff;
   assign last_code    = last_ff;
endmodule

[rtl/core/hcb_ctrl.sv]
module hcb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_final,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  hcb_pkg::sts_type  sts,
   output hcb_pkg::cmd_type  cmd
);
   import hcb_pkg::*;

   typedef enum logic [8:0] {
      S_LOAD  = 9'b000000001,
      S_MERGE = 9'b000000010,
      S_TRD   = 9'b000000100,
      S_TWL   = 9'b000001000,
      S_TWR   = 9'b000010000,
      S_ERD   = 9'b000100000,
      S_EWAIT = 9'b001000000,
      S_EHOLD = 9'b010000000,
      S_SPARE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_final) state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            if (sts.len_gt1) begin
               cmd.merge = 1'b1;
            end else if (sts.no_merges) begin
               cmd.single = 1'b1;
               state_in   = S_ERD;
            end else begin
               cmd.root = 1'b1;
               state_in = S_TRD;
            end
         end
         S_TRD: begin
            cmd.tree_rd = 1'b1;
            state_in    = S_TWL;
         end
         S_TWL: begin
            cmd.wr_left = 1'b1;
            state_in    = S_TWR;
         end
         S_TWR: begin
            cmd.wr_right = 1'b1;
            state_in     = sts.k_zero ? S_ERD : S_TRD;
         end
         S_ERD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EWAIT;
         end
         S_EWAIT: begin
            cmd.emit_load = 1'b1;
            state_in      = S_EHOLD;
         end
         S_EHOLD: begin
            if (rsp_ready) begin
               if (sts.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = S_ERD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = (state_ff == S_EHOLD);
endmodule

[rtl/core/huffman_code_builder.sv]
// Load: one request per cycle; frequencies go into a sorted list of leaf cells.
// Build after the final request of n symbols: n-1 merges (one add and compare each) and
// a root step (a single-symbol step when n is 1), then a tree read, a left write and
// a right write per merge to walk the tree through the code memory.
// Emit: read, load and hold per code, holding while rsp_ready is low; n codes per batch.
// Synchronous reset clears counters and the controller; memories are not cleared.
`include "huffman_code_builder_macros.svh"

module huffman_code_builder (
   input  logic        clock,
   input  logic        reset,
   hcb_req_if.sink     req_chan,
   hcb_rsp_if.source   rsp_chan
);
   import hcb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   hcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_final (req_chan.final_symbol),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hcb_path u_path (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .frequency    (req_chan.frequency),
      .symbol_index (rsp_chan.symbol_index),
      .code_value   (rsp_chan.code_value),
      .code_length  (rsp_chan.code_length),
      .overflow     (rsp_chan.overflow),
      .last_code    (rsp_chan.last_code)
   );

   `HCB_ASSERT_NOW(a_no_overlap, !(req_chan.ready && rsp_chan.valid), "load and emit overlap")
   `HCB_ASSERT_NOW(a_merge_len, !cmd.merge || sts.len_gt1, "merge with fewer than two nodes")
   `HCB_ASSERT_NEXT(a_back_load, rsp_chan.valid && rsp_chan.ready && rsp_chan.last_code, req_chan.ready, "no return to load after last code")
endmodule
